### design/sal_pkg.sv
// ---------------------------------------------------------------------------
// sal_pkg
// Shared constants, payload structs and controller/datapath interface types
// for the suffix array and LCP builder.
// ---------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  localparam int unsigned MAX_LEN    = 64;
  localparam int unsigned ALPHABET   = 30;

  localparam int unsigned SYM_W      = 5;
  localparam int unsigned POS_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned K_W        = POS_W + 1;
  localparam int unsigned LCP_W      = 6;

  localparam int unsigned TXT_DEPTH  = MAX_LEN + 2;
  localparam int unsigned TXT_AW     = $clog2(TXT_DEPTH);
  localparam int unsigned RANK_DEPTH = MAX_LEN + 1;
  localparam int unsigned RK_AW      = $clog2(RANK_DEPTH);
  localparam int unsigned BUCKETS    = ALPHABET + MAX_LEN + 2;
  localparam int unsigned CNT_AW     = $clog2(BUCKETS);
  localparam int unsigned IDX_W      = (CNT_AW > POS_W) ? CNT_AW : POS_W;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             final_symbol;
  } sal_in_t;

  typedef struct packed {
    logic [POS_W-1:0] suffix_start;
    logic [LCP_W-1:0] common_prefix;
    logic             last_result;
  } sal_out_t;

  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_CLR   = 12'b0000_0000_0010,
    PH_CNT   = 12'b0000_0000_0100,
    PH_PFX   = 12'b0000_0000_1000,
    PH_DIST  = 12'b0000_0001_0000,
    PH_YTAIL = 12'b0000_0010_0000,
    PH_YSA   = 12'b0000_0100_0000,
    PH_RANK  = 12'b0000_1000_0000,
    PH_CHECK = 12'b0001_0000_0000,
    PH_FR    = 12'b0010_0000_0000,
    PH_LCP   = 12'b0100_0000_0000,
    PH_EMIT  = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   first;  // initial single-symbol sort, before any doubling round
  } sal_cmd_t;

  typedef struct packed {
    logic done;     // current phase finished this cycle
    logic stop;     // ranks all distinct or step past text length
  } sal_status_t;

endpackage

`default_nettype wire

### design/suffix_array_lcp_builder.sv
// Loading accepts one symbol per cycle while idle; the final symbol starts construction.
// Each doubling round makes two bucket-memory sweeps plus per-element
// multi-cycle passes; up to log2(n)+1 rounds.
// The LCP pass visits each suffix and compares one more character per match;
// emit presents one result at a time and holds while the receiver stalls. One text is processed at a time.
// Async active-low reset returns to an empty text; memories are not cleared.
// ---------------------------------------------------------------------------
// suffix_array_lcp_builder
// Suffix array by prefix doubling with counting sort, LCP by Kasai's method.
// ---------------------------------------------------------------------------
`default_nettype none

module suffix_array_lcp_builder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sal_pkg::sal_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sal_pkg::sal_out_t      out_data_o
);
  import sal_pkg::*;

  sal_cmd_t    cmd;
  sal_status_t status;
  logic        in_accept;

  assign in_stall_o = (cmd.phase != PH_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  sal_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i  (in_accept && in_data_i.final_symbol),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sal_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .status_o    (status),
    .in_accept_i (in_accept),
    .in_data_i,
    .out_stall_i,
    .out_valid_o,
    .out_data_o
  );

endmodule

`default_nettype wire

### design/sal_ram.sv
// ---------------------------------------------------------------------------
// sal_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/sal_ctrl.sv
// ---------------------------------------------------------------------------
// sal_ctrl
// Phase sequencer: load, doubling rounds, final rank, LCP and emit.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire sal_pkg::sal_status_t status_i,
  output sal_pkg::sal_cmd_t         cmd_o
);
  import sal_pkg::*;

  phase_e state_q, state_d;
  logic   first_q, first_d;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    unique case (state_q)
      PH_IDLE: begin
        if (start_i) begin
          state_d = PH_CLR;
          first_d = 1'b1;
        end
      end
      PH_CLR:   if (status_i.done) state_d = PH_CNT;
      PH_CNT:   if (status_i.done) state_d = PH_PFX;
      PH_PFX:   if (status_i.done) state_d = PH_DIST;
      PH_DIST: begin
        if (status_i.done) begin
          state_d = first_q ? PH_YTAIL : PH_RANK;
          first_d = 1'b0;
        end
      end
      PH_YTAIL: if (status_i.done) state_d = PH_YSA;
      PH_YSA:   if (status_i.done) state_d = PH_CLR;
      PH_RANK:  if (status_i.done) state_d = PH_CHECK;
      PH_CHECK: state_d = status_i.stop ? PH_FR : PH_YTAIL;
      PH_FR:    if (status_i.done) state_d = PH_LCP;
      PH_LCP:   if (status_i.done) state_d = PH_EMIT;
      PH_EMIT:  if (status_i.done) state_d = PH_IDLE;
      default:  state_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  assign cmd_o.phase = state_q;
  assign cmd_o.first = first_q;

endmodule

`default_nettype wire

### design/sal_dp.sv
// ---------------------------------------------------------------------------
// sal_dp
// Datapath: text, rank, bucket, suffix, final rank and LCP memories with
// the per-phase index counters and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sal_pkg::sal_cmd_t    cmd_i,
  output sal_pkg::sal_status_t      status_o,
  input  wire logic                 in_accept_i,
  input  wire sal_pkg::sal_in_t     in_data_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output sal_pkg::sal_out_t         out_data_o
);
  import sal_pkg::*;

  // memory ports
  logic              t_we;
  logic [TXT_AW-1:0] t_wa, t_ra;
  logic [SYM_W-1:0]  t_wd, t_rd;
  logic              x_we, y_we, a_we, b_we;
  logic [RK_AW-1:0]  x_wa, x_ra, y_wa, y_ra, a_wa, a_ra, b_wa, b_ra;
  logic [POS_W-1:0]  x_wd, y_wd, a_wd, b_wd, x_rd, y_rd, a_rd, b_rd;
  logic              s_we, f_we, l_we, c_we;
  logic [RK_AW-1:0]  s_wa, s_ra, f_wa, f_ra, l_wa, l_ra;
  logic [POS_W-1:0]  s_wd, s_rd, f_wd, f_rd, l_wd, l_rd;
  logic [CNT_AW-1:0] c_wa, c_ra;
  logic [POS_W-1:0]  c_wd, c_rd;

  // control and working registers
  logic [IDX_W-1:0]  i_q, i_d;
  logic [2:0]        sub_q, sub_d;
  logic              fresh_q, fresh_d;
  logic [POS_W-1:0]  len_q, len_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              bank_q, bank_d;
  logic [POS_W-1:0]  p_q, p_d;
  logic [POS_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]  key_q, key_d;
  logic [POS_W-1:0]  apos_q, apos_d;
  logic [POS_W-1:0]  ya_q, ya_d;
  logic [POS_W-1:0]  pya_q, pya_d;
  logic [POS_W-1:0]  pyak_q, pyak_d;
  logic [POS_W-1:0]  rank_q, rank_d;
  logic [POS_W-1:0]  h_q, h_d;
  logic [POS_W-1:0]  r_q, r_d;
  logic [POS_W-1:0]  j_q, j_d;
  logic [SYM_W-1:0]  ti_q, ti_d;
  logic              ov_q, ov_d;
  sal_out_t          od_q, od_d;

  logic              done;
  logic              last;
  logic [POS_W-1:0]  ipos;
  logic [K_W-1:0]    ak, ih, jh;
  logic [POS_W-1:0]  yak, nr, h_dec;
  logic [SYM_W-1:0]  sym;
  logic              same;

  sal_ram #(.WIDTH(SYM_W), .DEPTH(TXT_DEPTH)) u_txt (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(RANK_DEPTH)) u_rka (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(RANK_DEPTH)) u_rkb (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(RANK_DEPTH)) u_sa (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(BUCKETS)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(RANK_DEPTH)) u_fr (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));
  sal_ram #(.WIDTH(POS_W), .DEPTH(RANK_DEPTH)) u_lcp (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd));

  // current/previous rank arrays swap between the two banks each round
  always_comb begin
    if (!bank_q) begin
      a_we = x_we; a_wa = x_wa; a_wd = x_wd; a_ra = x_ra;
      b_we = y_we; b_wa = y_wa; b_wd = y_wd; b_ra = y_ra;
      x_rd = a_rd; y_rd = b_rd;
    end else begin
      a_we = y_we; a_wa = y_wa; a_wd = y_wd; a_ra = y_ra;
      b_we = x_we; b_wa = x_wa; b_wd = x_wd; b_ra = x_ra;
      x_rd = b_rd; y_rd = a_rd;
    end
  end

  assign last  = (i_q == IDX_W'(len_q));
  assign ipos  = POS_W'(i_q);
  assign ak    = K_W'(apos_q) + k_q;
  assign ih    = K_W'(ipos) + K_W'(h_q);
  assign jh    = K_W'(j_q) + K_W'(h_q);
  assign h_dec = (h_q != '0) ? h_q - POS_W'(1) : '0;
  assign yak   = (ak <= K_W'(len_q)) ? y_rd : '0;
  assign same  = (ya_q == pya_q) && (yak == pyak_q);
  assign nr    = (i_q == IDX_W'(1)) ? POS_W'(1) : rank_q + (same ? POS_W'(0) : POS_W'(1));

  always_comb begin
    if (in_data_i.symbol == '0) begin
      sym = SYM_W'(1);
    end else if (in_data_i.symbol > SYM_W'(ALPHABET)) begin
      sym = SYM_W'(ALPHABET);
    end else begin
      sym = in_data_i.symbol;
    end
  end

  always_comb begin
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    x_we = 1'b0; x_wa = '0; x_wd = '0; x_ra = '0;
    y_we = 1'b0; y_wa = '0; y_wd = '0; y_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    i_d = i_q; sub_d = sub_q; fresh_d = fresh_q; len_d = len_q; k_d = k_q;
    bank_d = bank_q; p_d = p_q; acc_d = acc_q; key_d = key_q; apos_d = apos_q;
    ya_d = ya_q; pya_d = pya_q; pyak_d = pyak_q; rank_d = rank_q; h_d = h_q;
    r_d = r_q; j_d = j_q; ti_d = ti_q;
    ov_d = ov_q & out_stall_i;
    od_d = od_q;
    done = 1'b0;

    if (fresh_q && cmd_i.phase != PH_IDLE && cmd_i.phase != PH_CHECK) begin
      fresh_d = 1'b0;
      sub_d   = '0;
      case (cmd_i.phase)
        PH_CLR, PH_PFX: begin
          i_d   = '0;
          acc_d = '0;
        end
        PH_DIST:  i_d = IDX_W'(len_q);
        PH_YTAIL: begin
          i_d = IDX_W'(K_W'(len_q) - k_q + K_W'(1));
          p_d = '0;
        end
        PH_LCP: begin
          i_d = IDX_W'(1);
          h_d = '0;
        end
        default:  i_d = IDX_W'(1);
      endcase
    end else begin
      case (cmd_i.phase)
        PH_IDLE: begin
          if (in_accept_i) begin
            if (len_q < POS_W'(MAX_LEN)) begin
              t_we  = 1'b1;
              t_wa  = TXT_AW'(len_q + POS_W'(1));
              t_wd  = sym;
              len_d = len_q + POS_W'(1);
            end
            if (in_data_i.final_symbol) begin
              k_d     = K_W'(1);
              bank_d  = 1'b0;
              fresh_d = 1'b1;
            end
          end
        end

        PH_CLR: begin
          c_we = 1'b1;
          c_wa = CNT_AW'(i_q);
          if (i_q == IDX_W'(BUCKETS - 1)) done = 1'b1;
          else i_d = i_q + IDX_W'(1);
        end

        PH_CNT: begin
          case (sub_q)
            3'd0: begin
              t_ra  = TXT_AW'(ipos);
              x_ra  = RK_AW'(ipos);
              sub_d = 3'd1;
            end
            3'd1: begin
              key_d = cmd_i.first ? POS_W'(t_rd) : x_rd;
              if (cmd_i.first) begin
                x_we = 1'b1;
                x_wa = RK_AW'(ipos);
                x_wd = POS_W'(t_rd);
              end
              c_ra  = CNT_AW'(key_d);
              sub_d = 3'd2;
            end
            default: begin
              c_we  = 1'b1;
              c_wa  = CNT_AW'(key_q);
              c_wd  = c_rd + POS_W'(1);
              sub_d = 3'd0;
              if (last) done = 1'b1;
              else i_d = i_q + IDX_W'(1);
            end
          endcase
        end

        PH_PFX: begin
          if (sub_q == 3'd0) begin
            c_ra  = CNT_AW'(i_q);
            sub_d = 3'd1;
          end else begin
            acc_d = acc_q + c_rd;
            c_we  = 1'b1;
            c_wa  = CNT_AW'(i_q);
            c_wd  = acc_d;
            sub_d = 3'd0;
            if (i_q == IDX_W'(BUCKETS - 1)) done = 1'b1;
            else i_d = i_q + IDX_W'(1);
          end
        end

        PH_DIST: begin
          case (sub_q)
            3'd0: begin
              y_ra  = RK_AW'(ipos);
              sub_d = 3'd1;
            end
            3'd1: begin
              apos_d = cmd_i.first ? ipos : y_rd;
              x_ra   = RK_AW'(apos_d);
              sub_d  = 3'd2;
            end
            3'd2: begin
              key_d = x_rd;
              c_ra  = CNT_AW'(x_rd);
              sub_d = 3'd3;
            end
            default: begin
              s_we  = 1'b1;
              s_wa  = RK_AW'(c_rd);
              s_wd  = apos_q;
              c_we  = 1'b1;
              c_wa  = CNT_AW'(key_q);
              c_wd  = c_rd - POS_W'(1);
              sub_d = 3'd0;
              if (i_q == IDX_W'(1)) begin
                done = 1'b1;
                if (!cmd_i.first) bank_d = ~bank_q;
              end else begin
                i_d = i_q - IDX_W'(1);
              end
            end
          endcase
        end

        PH_YTAIL: begin
          y_we = 1'b1;
          y_wa = RK_AW'(p_q + POS_W'(1));
          y_wd = ipos;
          p_d  = p_q + POS_W'(1);
          if (last) done = 1'b1;
          else i_d = i_q + IDX_W'(1);
        end

        PH_YSA: begin
          if (sub_q == 3'd0) begin
            s_ra  = RK_AW'(ipos);
            sub_d = 3'd1;
          end else begin
            if (K_W'(s_rd) > k_q) begin
              y_we = 1'b1;
              y_wa = RK_AW'(p_q + POS_W'(1));
              y_wd = POS_W'(K_W'(s_rd) - k_q);
              p_d  = p_q + POS_W'(1);
            end
            sub_d = 3'd0;
            if (last) done = 1'b1;
            else i_d = i_q + IDX_W'(1);
          end
        end

        PH_RANK: begin
          case (sub_q)
            3'd0: begin
              s_ra  = RK_AW'(ipos);
              sub_d = 3'd1;
            end
            3'd1: begin
              apos_d = s_rd;
              y_ra   = RK_AW'(s_rd);
              sub_d  = 3'd2;
            end
            3'd2: begin
              ya_d  = y_rd;
              y_ra  = RK_AW'(ak);
              sub_d = 3'd3;
            end
            default: begin
              x_we   = 1'b1;
              x_wa   = RK_AW'(apos_q);
              x_wd   = nr;
              rank_d = nr;
              pya_d  = ya_q;
              pyak_d = yak;
              sub_d  = 3'd0;
              if (last) begin
                done = 1'b1;
                k_d  = k_q << 1;
              end else begin
                i_d = i_q + IDX_W'(1);
              end
            end
          endcase
        end

        PH_FR: begin
          if (sub_q == 3'd0) begin
            s_ra  = RK_AW'(ipos);
            sub_d = 3'd1;
          end else begin
            f_we  = 1'b1;
            f_wa  = RK_AW'(s_rd);
            f_wd  = ipos;
            sub_d = 3'd0;
            if (last) done = 1'b1;
            else i_d = i_q + IDX_W'(1);
          end
        end

        PH_LCP: begin
          case (sub_q)
            3'd0: begin
              f_ra  = RK_AW'(ipos);
              sub_d = 3'd1;
            end
            3'd1: begin
              r_d = f_rd;
              if (f_rd <= POS_W'(1)) begin
                // first suffix in sorted order has no predecessor
                l_we  = 1'b1;
                l_wa  = RK_AW'(1);
                h_d   = '0;
                sub_d = 3'd0;
                if (last) done = 1'b1;
                else i_d = i_q + IDX_W'(1);
              end else begin
                s_ra  = RK_AW'(f_rd - POS_W'(1));
                sub_d = 3'd2;
              end
            end
            3'd2: begin
              j_d   = s_rd;
              sub_d = 3'd3;
            end
            3'd3: begin
              if (ih <= K_W'(len_q) && jh <= K_W'(len_q)) begin
                t_ra  = TXT_AW'(ih);
                sub_d = 3'd4;
              end else begin
                l_we  = 1'b1;
                l_wa  = RK_AW'(r_q);
                l_wd  = h_q;
                h_d   = h_dec;
                sub_d = 3'd0;
                if (last) done = 1'b1;
                else i_d = i_q + IDX_W'(1);
              end
            end
            3'd4: begin
              ti_d  = t_rd;
              t_ra  = TXT_AW'(jh);
              sub_d = 3'd5;
            end
            default: begin
              if (t_rd == ti_q) begin
                h_d   = h_q + POS_W'(1);
                sub_d = 3'd3;
              end else begin
                l_we  = 1'b1;
                l_wa  = RK_AW'(r_q);
                l_wd  = h_q;
                h_d   = h_dec;
                sub_d = 3'd0;
                if (last) done = 1'b1;
                else i_d = i_q + IDX_W'(1);
              end
            end
          endcase
        end

        PH_EMIT: begin
          s_ra = RK_AW'(ipos);
          l_ra = RK_AW'(ipos);
          if (sub_q == 3'd0) begin
            sub_d = 3'd1;
          end else if (!ov_q || !out_stall_i) begin
            ov_d                = 1'b1;
            od_d.suffix_start   = s_rd;
            od_d.common_prefix  = l_rd[LCP_W-1:0];
            od_d.last_result    = last;
            sub_d               = 3'd0;
            if (last) begin
              done  = 1'b1;
              len_d = '0;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end
        end

        default: ;
      endcase
    end

    if (done) fresh_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      sub_q   <= '0;
      fresh_q <= 1'b0;
      len_q   <= '0;
      k_q     <= K_W'(1);
      bank_q  <= 1'b0;
      p_q     <= '0;
      rank_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      i_q     <= i_d;
      sub_q   <= sub_d;
      fresh_q <= fresh_d;
      len_q   <= len_d;
      k_q     <= k_d;
      bank_q  <= bank_d;
      p_q     <= p_d;
      rank_q  <= rank_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    key_q  <= key_d;
    apos_q <= apos_d;
    ya_q   <= ya_d;
    pya_q  <= pya_d;
    pyak_q <= pyak_d;
    h_q    <= h_d;
    r_q    <= r_d;
    j_q    <= j_d;
    ti_q   <= ti_d;
    od_q   <= od_d;
  end

  assign status_o.done = done;
  assign status_o.stop = (rank_q == len_q) || (k_q > K_W'(len_q));
  assign out_valid_o   = ov_q;
  assign out_data_o    = od_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= POS_W'(MAX_LEN))
    else $error("text length exceeds maximum");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.phase == PH_RANK && !fresh_q && sub_q == 3'd3) |-> (IDX_W'(nr) <= i_q))
    else $error("rank exceeds sorted index");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("phase done held for two cycles");
`endif

endmodule

`default_nettype wire

### bench/sal_checker.sv
// ---------------------------------------------------------------------------
// sal_checker
// Watches both channels of the suffix array builder, predicts the sorted
// suffix list with LCPs for each finished text and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire sal_pkg::sal_in_t  in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire sal_pkg::sal_out_t out_data_i,
  output int                     errors_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  localparam int TL = MAX_LEN;

  int       text_q[$];       // clamped symbols of the text being loaded
  sal_out_t suffix_q[$];     // expected results, oldest first

  // naive sort of suffixes plus direct LCP; equivalent to doubling + Kasai
  function automatic int cmp_suffix(int a, int b);
    int i;
    i = 0;
    while (a + i < text_q.size() && b + i < text_q.size()) begin
      if (text_q[a+i] != text_q[b+i]) return (text_q[a+i] < text_q[b+i]) ? -1 : 1;
      i++;
    end
    return ((text_q.size() - a) < (text_q.size() - b)) ? -1 : 1;
  endfunction

  function automatic int common_len(int a, int b);
    int i;
    i = 0;
    while (a + i < text_q.size() && b + i < text_q.size() && text_q[a+i] == text_q[b+i])
      i++;
    return i;
  endfunction

  task automatic predict_sorted();
    int order[$];
    int n, i, j, t;
    sal_out_t r;
    n = text_q.size();
    for (i = 0; i < n; i++) order.push_back(i);
    for (i = 1; i < n; i++) begin
      j = i;
      while (j > 0 && cmp_suffix(order[j], order[j-1]) < 0) begin
        t = order[j]; order[j] = order[j-1]; order[j-1] = t;
        j--;
      end
    end
    for (i = 0; i < n; i++) begin
      r.suffix_start  = POS_W'(order[i] + 1);
      r.common_prefix = (i == 0) ? '0 : LCP_W'(common_len(order[i], order[i-1]));
      r.last_result   = (i == n - 1);
      suffix_q.push_back(r);
    end
    text_q.delete();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int sym;
    int bad;
    sal_out_t e;
    if (!rst_ni) begin
      errors_o  <= 0;
      pending_o <= 0;
      text_q.delete();
      suffix_q.delete();
    end else begin
      bad = 0;
      if (in_valid_i && !in_stall_i) begin
        sym = in_data_i.symbol;
        if (sym == 0) sym = 1;
        if (sym > ALPHABET) sym = ALPHABET;
        if (text_q.size() < TL) text_q.push_back(sym);
        if (in_data_i.final_symbol) predict_sorted();
      end
      if (out_valid_i && !out_stall_i) begin
        if (suffix_q.size() == 0) begin
          $error("unexpected request out: start %0d", out_data_i.suffix_start);
          bad++;
        end else begin
          e = suffix_q.pop_front();
          if (e.suffix_start !== out_data_i.suffix_start) begin
            $error("suffix_start exp %0d got %0d", e.suffix_start, out_data_i.suffix_start);
            bad++;
          end
          if (e.common_prefix !== out_data_i.common_prefix) begin
            $error("common_prefix exp %0d got %0d", e.common_prefix,
                   out_data_i.common_prefix);
            bad++;
          end
          if (e.last_result !== out_data_i.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, out_data_i.last_result);
            bad++;
          end
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= suffix_q.size() + text_q.size();
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Feeds texts (directed edge cases, then random texts) into the suffix
// array builder with random idling on both sides and gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  localparam int WATCHDOG = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sal_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sal_out_t out_data;
  int       errors, pending;
  int       idle_cnt = 0;
  bit       quiet = 1'b0;     // no idling in the closing part
  bit       hold_off = 1'b0;  // long receiver stall request
  bit       stim_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  suffix_array_lcp_builder dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sal_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  // valid stays high between back-to-back requests; dropped only for a gap
  task automatic send(input logic [4:0] sym, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, final_symbol: fin};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_text(input int len, input int kind);
    int i;
    logic [4:0] s;
    for (i = 0; i < len; i++) begin
      case (kind)
        0: s = 5'($urandom_range(1, 30));
        1: s = 5'($urandom_range(1, 2));     // repetitive, long LCPs
        2: s = 5'($urandom);                 // includes zero and above range
        default: s = 5'(1 + (i % 3));
      endcase
      send(s, i == len - 1);
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    int n;
    if (hold_off) out_stall <= 1'b1;
    else if (idle_cnt > 0) idle_cnt <= idle_cnt - 1;
    else if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      idle_cnt <= n - 1;
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // watchdog on acceptance-free cycles
  always @(posedge clk_i) begin
    int still;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) still = 0;
    else still++;
    if (still >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int items;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: single symbol, both field extremes, zero and saturating codes
    send(5'd1, 1'b1);
    send(5'd30, 1'b0); send(5'd1, 1'b1);
    send(5'd0, 1'b0); send(5'd31, 1'b0); send(5'd1, 1'b0); send(5'd30, 1'b1);
    send_text(6, 3);
    send_text(8, 1);
    // long receiver hold-off while the sender keeps offering texts
    fork
      begin hold_off = 1'b1; repeat (20000) @(posedge clk_i); hold_off = 1'b0; end
    join_none
    // overlong text: symbols past the limit dropped, final on a dropped one
    send_text(70, 2);
    send_text(64, 1);
    items = 0;
    while (items < 265) begin
      automatic int len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
                                                      : $urandom_range(1, 12);
      automatic int kind = $urandom_range(0, 2);
      if (items > 215) quiet = 1'b1;
      send_text(len, kind);
      items += len;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
